>>> hdl/ffa_pkg.sv
`timescale 1ns / 1ps
package ffa_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INIT,
    ST_LAUNCH,
    ST_WALK,
    ST_NEXT,
    ST_PREV,
    ST_SCAN,
    ST_WNEW,
    ST_WCUR,
    ST_RESP
  } ffa_state_t;

  typedef enum logic [1:0] {
    RES_DONE  = 2'd0,
    RES_ZERO  = 2'd1,
    RES_NOFIT = 2'd2
  } ffa_res_t;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_SUCC,
    RD_PREV
  } ffa_rd_t;

  typedef struct packed {
    logic     load_req;
    logic     walk_init;
    logic     init_wr;
    logic     walk;
    logic     nx_step;
    logic     pv_step;
    logic     scan;
    logic     wr_new;
    logic     wr_cur;
    logic     load_out;
    logic     grant;
    ffa_res_t code;
    ffa_rd_t  rd_sel;
  } ffa_ctrl_t;

  typedef struct packed {
    logic is_free;
    logic size_zero;
    logic started;
    logic hit;
    logic stop;
    logic has_succ;
    logic have_prev;
    logic split;
    logic slot_free;
    logic scan_last;
    logic out_busy;
  } ffa_stat_t;

endpackage

>>> hdl/ffa_ctrl.sv
`timescale 1ns / 1ps
module ffa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ffa_pkg::ffa_stat_t stat,
  output ffa_pkg::ffa_ctrl_t ctrl
);
  import ffa_pkg::*;

  ffa_state_t state_r, state_nxt;
  ffa_res_t   code_r, code_nxt;
  logic       grant_r, grant_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      code_r  <= RES_DONE;
      grant_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
      grant_r <= grant_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    grant_nxt = grant_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        code_nxt  = RES_DONE;
        grant_nxt = 1'b0;
        if (!stat.is_free && stat.size_zero) begin
          code_nxt  = RES_ZERO;
          state_nxt = ST_RESP;
        end else if (!stat.started) begin
          state_nxt = stat.is_free ? ST_RESP : ST_INIT;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_INIT:   state_nxt = ST_LAUNCH;
      ST_LAUNCH: state_nxt = ST_WALK;
      ST_WALK: begin
        if (stat.hit) begin
          if (!stat.is_free) state_nxt = stat.split ? ST_SCAN : ST_WCUR;
          else if (stat.has_succ) state_nxt = ST_NEXT;
          else if (stat.have_prev) state_nxt = ST_PREV;
          else state_nxt = ST_WCUR;
        end else if (stat.stop) begin
          code_nxt  = stat.is_free ? RES_DONE : RES_NOFIT;
          state_nxt = ST_RESP;
        end
      end
      ST_NEXT:  state_nxt = stat.have_prev ? ST_PREV : ST_WCUR;
      ST_PREV:  state_nxt = ST_RESP;
      ST_SCAN: begin
        if (stat.slot_free) state_nxt = ST_WNEW;
        else if (stat.scan_last) state_nxt = ST_WCUR;
      end
      ST_WNEW:  state_nxt = ST_WCUR;
      ST_WCUR: begin
        grant_nxt = !stat.is_free;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!stat.out_busy) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl        = '0;
    ctrl.rd_sel = RD_SUCC;
    ctrl.code   = code_r;
    ctrl.grant  = grant_r;
    in_tready   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready     = 1'b1;
        ctrl.load_req = in_tvalid;
      end
      ST_DECODE: begin
        ctrl.rd_sel    = RD_ZERO;
        ctrl.walk_init = 1'b1;
      end
      ST_INIT: ctrl.init_wr = 1'b1;
      ST_LAUNCH: begin
        ctrl.rd_sel    = RD_ZERO;
        ctrl.walk_init = 1'b1;
      end
      ST_WALK: begin
        ctrl.walk = 1'b1;
        if (stat.hit && stat.is_free && !stat.has_succ) ctrl.rd_sel = RD_PREV;
      end
      ST_NEXT: begin
        ctrl.nx_step = 1'b1;
        ctrl.rd_sel  = RD_PREV;
      end
      ST_PREV: ctrl.pv_step = 1'b1;
      ST_SCAN: ctrl.scan = 1'b1;
      ST_WNEW: ctrl.wr_new = 1'b1;
      ST_WCUR: ctrl.wr_cur = 1'b1;
      ST_RESP: ctrl.load_out = !stat.out_busy;
      default: ctrl = '0;
    endcase
  end

endmodule

>>> hdl/ffa_datapath.sv
`timescale 1ns / 1ps
module ffa_datapath #(
  parameter int ARENA_BYTES  = 1024,
  parameter int HEADER_BYTES = 28,
  parameter int MAX_BLOCKS   = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [23:0]        in_tdata,
  input  logic               in_tuser,
  input  logic               out_tready,
  output logic               out_tvalid,
  output logic [15:0]        out_tdata,
  input  ffa_pkg::ffa_ctrl_t ctrl,
  output ffa_pkg::ffa_stat_t stat
);
  import ffa_pkg::*;

  localparam int BW = $clog2(ARENA_BYTES + 1);
  localparam int CW = ((BW > 11) ? BW : 11) + 1;
  localparam int SW = $clog2(MAX_BLOCKS);
  localparam logic [BW-1:0] HDR = BW'(HEADER_BYTES);
  localparam logic [BW-1:0] INIT_BYTES =
    BW'((ARENA_BYTES > HEADER_BYTES) ? (ARENA_BYTES - HEADER_BYTES) : 0);
  localparam logic [SW-1:0] LAST = SW'(MAX_BLOCKS - 1);

  typedef struct packed {
    logic [BW-1:0] start;
    logic [BW-1:0] bytes;
    logic          avail;
    logic [SW-1:0] succ;
    logic          has;
  } ent_t;

  ent_t mem [MAX_BLOCKS];
  ent_t rd_q;
  ent_t cur_e_r;
  ent_t wd;
  logic [SW-1:0] ra, wa;
  logic          we;

  logic [MAX_BLOCKS-1:0] slot_r;
  logic          started_r;
  logic          free_r;
  logic [10:0]   size_r;
  logic [9:0]    off_r;
  logic [SW-1:0] cur_r, prev_r, nx_r, ns_r, n_r, s_r;
  logic          have_prev_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [9:0]    out_off_r;

  logic [CW-1:0] size_c, bytes_c, cur_start_c, new_start_c, new_bytes_c;
  logic          fit, match_off, hit;

  assign size_c      = CW'(size_r);
  assign bytes_c     = CW'(rd_q.bytes);
  assign fit         = rd_q.avail && (bytes_c >= size_c);
  assign match_off   = CW'(rd_q.start) == CW'(off_r);
  assign hit         = free_r ? match_off : fit;
  assign cur_start_c = CW'(cur_e_r.start);
  assign new_start_c = cur_start_c + size_c + CW'(HEADER_BYTES);
  assign new_bytes_c = CW'(cur_e_r.bytes) - size_c - CW'(HEADER_BYTES);

  always_comb begin
    stat.is_free   = free_r;
    stat.size_zero = size_r == 11'd0;
    stat.started   = started_r;
    stat.hit       = hit;
    stat.stop      = !rd_q.has || (n_r == LAST);
    stat.has_succ  = rd_q.has;
    stat.have_prev = have_prev_r;
    stat.split     = bytes_c > (size_c + CW'(HEADER_BYTES));
    stat.slot_free = !slot_r[s_r];
    stat.scan_last = s_r == LAST;
    stat.out_busy  = out_valid_r && !out_tready;
  end

  always_comb begin
    case (ctrl.rd_sel)
      RD_ZERO: ra = '0;
      RD_PREV: ra = prev_r;
      default: ra = rd_q.succ;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = cur_r;
    wd = cur_e_r;
    if (ctrl.init_wr) begin
      we = 1'b1;
      wa = '0;
      wd = '{start: HDR, bytes: INIT_BYTES, avail: 1'b1, succ: '0, has: 1'b0};
    end else if (ctrl.wr_new) begin
      we = 1'b1;
      wa = ns_r;
      wd = '{start: new_start_c[BW-1:0], bytes: new_bytes_c[BW-1:0], avail: 1'b1,
             succ: cur_e_r.succ, has: cur_e_r.has};
    end else if (ctrl.wr_cur) begin
      we = 1'b1;
    end else if (ctrl.pv_step) begin
      we = 1'b1;
      if (rd_q.avail) begin
        wa = prev_r;
        wd = '{start: rd_q.start, bytes: rd_q.bytes + HDR + cur_e_r.bytes,
               avail: 1'b1, succ: cur_e_r.succ, has: cur_e_r.has};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r    <= '0;
      started_r <= 1'b0;
    end else begin
      if (ctrl.init_wr) begin
        slot_r[0] <= 1'b1;
        started_r <= 1'b1;
      end
      if (ctrl.scan && !slot_r[s_r]) slot_r[s_r] <= 1'b1;
      if (ctrl.nx_step && rd_q.avail) slot_r[nx_r] <= 1'b0;
      if (ctrl.pv_step && rd_q.avail) slot_r[cur_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_req) begin
      free_r <= in_tuser;
      size_r <= in_tdata[10:0];
      off_r  <= in_tdata[20:11];
    end
    if (ctrl.walk_init) begin
      cur_r       <= '0;
      n_r         <= '0;
      s_r         <= '0;
      have_prev_r <= 1'b0;
    end
    if (ctrl.walk) begin
      if (hit) begin
        cur_e_r <= '{start: rd_q.start, bytes: rd_q.bytes, avail: free_r,
                     succ: rd_q.succ, has: rd_q.has};
        nx_r    <= rd_q.succ;
      end else begin
        prev_r      <= cur_r;
        have_prev_r <= 1'b1;
        cur_r       <= rd_q.succ;
        n_r         <= n_r + 1'b1;
      end
    end
    if (ctrl.nx_step && rd_q.avail) begin
      cur_e_r.bytes <= cur_e_r.bytes + HDR + rd_q.bytes;
      cur_e_r.succ  <= rd_q.succ;
      cur_e_r.has   <= rd_q.has;
    end
    if (ctrl.scan) begin
      if (!slot_r[s_r]) ns_r <= s_r;
      else if (s_r != LAST) s_r <= s_r + 1'b1;
    end
    if (ctrl.wr_new) begin
      cur_e_r.bytes <= size_c[BW-1:0];
      cur_e_r.succ  <= ns_r;
      cur_e_r.has   <= 1'b1;
    end
    if (ctrl.load_out) begin
      out_status_r <= ctrl.code;
      out_off_r    <= ctrl.grant ? cur_start_c[9:0] : 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (ctrl.load_out) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_off_r, out_status_r};

  a_head_kept: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> slot_r[0]) else $error("head slot released");
  a_started_stays: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r) else $error("arena start flag dropped");
  a_new_slot_claimed: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wr_new |-> slot_r[ns_r]) else $error("split into unclaimed slot");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load_out |-> !(out_valid_r && !out_tready)) else $error("result overwritten");

endmodule

>>> hdl/first_fit_allocator_split_coalesce_unit.sv
`timescale 1ns / 1ps
// first-fit heap allocator over a byte arena kept as an address-ordered block list in an
// on-chip table; one transaction at a time: accept, decode, the list walk at one block per
// cycle (up to MAX_BLOCKS blocks), then up to two table writes and the result; the first
// allocate builds the list before its walk. an allocate that splits adds a slot search of
// one slot per cycle (up to MAX_BLOCKS slots) plus one more table write, and a stalled
// result holds the block until it is taken. the slot in-use bits are flip-flops cleared
// at reset, so no clearing pass is needed.
module first_fit_allocator_split_coalesce_unit #(
  parameter int ARENA_BYTES  = 1024,
  parameter int HEADER_BYTES = 28,
  parameter int MAX_BLOCKS   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // request_bytes[10:0], release_offset[20:11]
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status[1:0], payload_offset[11:2]
);
  import ffa_pkg::*;

  ffa_ctrl_t ctrl;
  ffa_stat_t stat;

  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  ffa_datapath #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .ctrl       (ctrl),
    .stat       (stat)
  );

endmodule
